// ===== sv/kbv_pkg.sv =====
// Shared constants and types for the knapsack best-value block.
`default_nettype none
package kbv_pkg;

    localparam int BUDGET_STEPS = 4096;
    localparam int ADDR_W       = $clog2(BUDGET_STEPS);

    localparam int PRICE_W      = 12;
    localparam int IMPORTANCE_W = 3;
    localparam int PARENT_W     = 7;
    localparam int BUDGET_W     = 12;
    localparam int VALUE_W      = 18;
    localparam int GAIN_W       = 19;
    localparam int SUM_W        = GAIN_W + 1;

    localparam int PRICE_UNIT   = 10;

    localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [GAIN_W-1:0]  gain_t;
    typedef logic [SUM_W-1:0]   sum_t;

endpackage
`default_nettype wire

// ===== sv/kbv_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module kbv_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== sv/knapsack_best_value.sv =====
// Top level: 0/1 knapsack best-value engine over a budget table in RAM.
`default_nettype none
// Items arrive one request at a time. A main item (parent_index zero, nonzero
// price and importance, price inside the table) sweeps the 4096-entry budget
// table from the top down, one entry per cycle through a read-modify-write
// pipeline on two mirrored RAMs (one read at b, one at b - price), ending at
// b = price. An item with last_item set then reads the entry at the
// configured budget (clamped to the table) into the output register and
// then clears the table. After reset the same clearing pass runs before
// the first item is taken. The budget register may be written at any time
// the block is idle; cfg_ready is always high.
module knapsack_best_value (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [kbv_pkg::BUDGET_W-1:0]  cfg_budget_tens,

    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [kbv_pkg::PRICE_W-1:0]   s_price_tens,
    input  wire logic [kbv_pkg::IMPORTANCE_W-1:0] s_importance,
    input  wire logic [kbv_pkg::PARENT_W-1:0]  s_parent_index,
    input  wire logic                          s_last_item,

    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [kbv_pkg::VALUE_W-1:0]        m_best_value
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_RESULT_RD,
        ST_RESULT_WAIT
    } state_t;

    localparam kbv_pkg::addr_t ADDR_TOP = kbv_pkg::addr_t'(kbv_pkg::BUDGET_STEPS - 1);
    localparam kbv_pkg::addr_t ADDR_ONE = kbv_pkg::addr_t'(1);

    state_t                        state_reg, state_next;
    kbv_pkg::addr_t                addr_reg, addr_next;
    logic [kbv_pkg::PRICE_W-1:0]   price_reg, price_next;
    kbv_pkg::gain_t                gain_reg, gain_next;
    logic                          last_reg, last_next;
    logic [kbv_pkg::BUDGET_W-1:0]  budget_reg, budget_next;
    logic                          wr_pend_reg, wr_pend_next;
    kbv_pkg::addr_t                wr_addr_reg, wr_addr_next;
    logic                          m_valid_reg, m_valid_next;
    kbv_pkg::value_t               m_best_value_reg, m_best_value_next;

    kbv_pkg::addr_t                price_addr;
    kbv_pkg::addr_t                budget_addr;
    kbv_pkg::gain_t                in_gain;
    logic                          in_main;

    logic                          ram_we;
    kbv_pkg::addr_t                ram_wr_addr;
    kbv_pkg::value_t               ram_wr_data;
    logic                          rd_a_en, rd_b_en;
    kbv_pkg::addr_t                rd_a_addr, rd_b_addr;
    kbv_pkg::value_t               rd_a_data, rd_b_data;

    kbv_pkg::sum_t                 cand_sum;
    kbv_pkg::value_t               cand;
    kbv_pkg::value_t               merged;

    logic                          in_fire;
    logic                          out_free;

    // Mirrored copies: same writes, independent read ports.
    kbv_ram #(
        .WIDTH (kbv_pkg::VALUE_W),
        .DEPTH (kbv_pkg::BUDGET_STEPS)
    ) u_ram_a (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (rd_a_en),
        .rd_addr (rd_a_addr),
        .rd_data (rd_a_data)
    );

    kbv_ram #(
        .WIDTH (kbv_pkg::VALUE_W),
        .DEPTH (kbv_pkg::BUDGET_STEPS)
    ) u_ram_b (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (rd_b_en),
        .rd_addr (rd_b_addr),
        .rd_data (rd_b_data)
    );

    assign cfg_ready    = 1'b1;
    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_best_value = m_best_value_reg;

    assign in_fire  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign in_gain = kbv_pkg::gain_t'(s_price_tens) * kbv_pkg::gain_t'(kbv_pkg::PRICE_UNIT)
                   * kbv_pkg::gain_t'(s_importance);
    assign in_main = (s_parent_index == '0) && (in_gain != '0)
                   && (32'(s_price_tens) < 32'(kbv_pkg::BUDGET_STEPS));

    assign price_addr  = kbv_pkg::addr_t'(price_reg);
    assign budget_addr = (32'(budget_reg) >= 32'(kbv_pkg::BUDGET_STEPS))
                       ? ADDR_TOP : kbv_pkg::addr_t'(budget_reg);

    // Read side: the entry itself and the entry one price below.
    assign rd_a_en   = (state_reg == ST_SWEEP) || (state_reg == ST_RESULT_RD);
    assign rd_a_addr = (state_reg == ST_SWEEP) ? addr_reg : budget_addr;
    assign rd_b_en   = (state_reg == ST_SWEEP);
    assign rd_b_addr = addr_reg - price_addr;

    // Downward sweep: pending write lands above every address still to be read.
    assign cand_sum = kbv_pkg::sum_t'(rd_b_data) + kbv_pkg::sum_t'(gain_reg);
    assign cand     = (cand_sum > kbv_pkg::sum_t'(kbv_pkg::VALUE_MAX))
                    ? kbv_pkg::VALUE_MAX : kbv_pkg::value_t'(cand_sum);
    assign merged   = (cand > rd_a_data) ? cand : rd_a_data;

    assign ram_we      = (state_reg == ST_CLEAR) || wr_pend_reg;
    assign ram_wr_addr = (state_reg == ST_CLEAR) ? addr_reg : wr_addr_reg;
    assign ram_wr_data = (state_reg == ST_CLEAR) ? '0 : merged;

    always_comb begin
        state_next        = state_reg;
        addr_next         = addr_reg;
        price_next        = price_reg;
        gain_next         = gain_reg;
        last_next         = last_reg;
        budget_next       = budget_reg;
        wr_pend_next      = 1'b0;
        wr_addr_next      = wr_addr_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_best_value_next = m_best_value_reg;

        if (cfg_valid && cfg_ready) begin
            budget_next = cfg_budget_tens;
        end

        case (state_reg)
            ST_CLEAR: begin
                if (addr_reg == ADDR_TOP) begin
                    state_next = ST_IDLE;
                end else begin
                    addr_next = addr_reg + ADDR_ONE;
                end
            end
            ST_IDLE: begin
                if (in_fire) begin
                    price_next = s_price_tens;
                    gain_next  = in_gain;
                    last_next  = s_last_item;
                    if (in_main) begin
                        state_next = ST_SWEEP;
                        addr_next  = ADDR_TOP;
                    end else if (s_last_item) begin
                        state_next = ST_RESULT_RD;
                    end
                end
            end
            ST_SWEEP: begin
                wr_pend_next = 1'b1;
                wr_addr_next = addr_reg;
                if (addr_reg == price_addr) begin
                    state_next = ST_DRAIN;
                end else begin
                    addr_next = addr_reg - ADDR_ONE;
                end
            end
            ST_DRAIN: begin
                state_next = last_reg ? ST_RESULT_RD : ST_IDLE;
            end
            ST_RESULT_RD: begin
                state_next = ST_RESULT_WAIT;
            end
            ST_RESULT_WAIT: begin
                if (out_free) begin
                    m_valid_next      = 1'b1;
                    m_best_value_next = rd_a_data;
                    state_next        = ST_CLEAR;
                    addr_next         = '0;
                end
            end
            default: begin
                state_next = ST_CLEAR;
                addr_next  = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            addr_reg    <= '0;
            budget_reg  <= '0;
            wr_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            last_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            addr_reg    <= addr_next;
            budget_reg  <= budget_next;
            wr_pend_reg <= wr_pend_next;
            m_valid_reg <= m_valid_next;
            last_reg    <= last_next;
        end
        price_reg        <= price_next;
        gain_reg         <= gain_next;
        wr_addr_reg      <= wr_addr_next;
        m_best_value_reg <= m_best_value_next;
    end

endmodule
`default_nettype wire
